>>> design/c16fd_pkg.sv
// Package for the CRC16 checked frame decoder: shared types, frame constants
// and the byte-wide CRC16-CCITT update function. No dependencies.
package c16fd_pkg;

   localparam logic [15:0] CrcInit     = 16'hFFFF;
   localparam logic [15:0] CrcPoly     = 16'h1021;
   localparam logic [7:0]  SyncByte0   = 8'hAA;
   localparam logic [7:0]  SyncByte1   = 8'h55;
   localparam logic [16:0] FrameOvhd   = 17'd10;
   localparam logic [16:0] PayloadOffs = 17'd8;
   localparam logic [15:0] PosMax      = 16'hFFFF;

   // header byte offsets
   localparam logic [15:0] PosSync0  = 16'd0;
   localparam logic [15:0] PosSync1  = 16'd1;
   localparam logic [15:0] PosVer    = 16'd2;
   localparam logic [15:0] PosCmd    = 16'd3;
   localparam logic [15:0] PosSeqLo  = 16'd4;
   localparam logic [15:0] PosSeqHi  = 16'd5;
   localparam logic [15:0] PosLenLo  = 16'd6;
   localparam logic [15:0] PosLenHi  = 16'd7;

   localparam logic [7:0]  VersionReset    = 8'd1;
   localparam logic [11:0] MaxPayloadReset = 12'd128;

   localparam logic KindPayload = 1'b0;
   localparam logic KindSummary = 1'b1;

   typedef enum logic {
      RegVersion    = 1'b0,
      RegMaxPayload = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [7:0]  protocol_version;
      logic [11:0] max_payload;
   } cfg_type;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  payload_byte;
      logic        frame_ok;
      logic [7:0]  command_code;
      logic [15:0] sequence_number;
      logic [15:0] payload_count;
   } result_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> design/crc16_checked_frame_decoder_core.sv
// Top level of the CRC16 checked frame decoder: input register, frame
// decode, result register and configuration port. Depends on c16fd_pkg.

// Takes one frame byte per request and gives back a payload byte for each
// payload position and one summary (ok flag, command, sequence, length) on the
// byte flagged as end of buffer; the CRC16-CCITT (0x1021, init 0xFFFF) covers
// all but the two trailing CRC bytes. A new byte is accepted every cycle while the
// path is not stalled: the request is registered in the input register, then
// decoded and its result written to the output register, and the only stall
// comes from a full output register that is not being drained.
module crc16_checked_frame_decoder_core
   import c16fd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_end_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_item_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_frame_ok,
   output logic [7:0]  rsp_command_code,
   output logic [15:0] rsp_sequence_number,
   output logic [15:0] rsp_payload_count,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type    cfg;
   logic       in_v_ff, in_v_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       out_v_ff, out_v_in;
   result_type out_ff;
   result_type res;
   logic       has_result;
   logic       out_free;
   logic       advance;
   logic       req_take;

   c16fd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   c16fd_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .rx_byte    (byte_ff),
      .last       (last_ff),
      .cfg        (cfg),
      .has_result (has_result),
      .result     (res)
   );

   assign out_free  = !out_v_ff || !rsp_stall;
   assign advance   = in_v_ff && (!has_result || out_free);
   assign req_stall = in_v_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_v_in = in_v_ff;
      if (advance || !in_v_ff) in_v_in = req_valid;
      out_v_in = out_v_ff;
      if (out_free) out_v_in = advance && has_result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         byte_ff <= req_rx_byte;
         last_ff <= req_end_of_buffer;
      end
      if (advance && has_result) begin
         out_ff <= res;
      end
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_item_kind       = out_ff.item_kind;
   assign rsp_payload_byte    = out_ff.payload_byte;
   assign rsp_frame_ok        = out_ff.frame_ok;
   assign rsp_command_code    = out_ff.command_code;
   assign rsp_sequence_number = out_ff.sequence_number;
   assign rsp_payload_count   = out_ff.payload_count;

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_v_ff && has_result && out_v_ff)
      else $error("request stalled with free path");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      advance && has_result |=> rsp_valid)
      else $error("decoded result not registered");

endmodule

>>> design/c16fd_csr.sv
// Configuration registers of the frame decoder behind an APB-style port.
// Depends on c16fd_pkg.
module c16fd_csr
   import c16fd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   logic [7:0]    version_ff;
   logic [7:0]    version_in;
   logic [11:0]   maxp_ff;
   logic [11:0]   maxp_in;
   logic          wr_en;
   reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = reg_index_type'(csr_paddr[2]);

   always_comb begin
      version_in = version_ff;
      maxp_in    = maxp_ff;
      csr_prdata = '0;
      unique case (idx)
         RegVersion: begin
            csr_prdata = {24'd0, version_ff};
            if (wr_en) version_in = csr_pwdata[7:0];
         end
         RegMaxPayload: begin
            csr_prdata = {20'd0, maxp_ff};
            if (wr_en) maxp_in = csr_pwdata[11:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VersionReset;
         maxp_ff    <= MaxPayloadReset;
      end else begin
         version_ff <= version_in;
         maxp_ff    <= maxp_in;
      end
   end

   assign cfg.protocol_version = version_ff;
   assign cfg.max_payload      = maxp_ff;

endmodule

>>> design/c16fd_frame.sv
// Frame state and per-byte decode: header checks, held fields, delayed CRC
// and the payload/summary result. Depends on c16fd_pkg.
module c16fd_frame
   import c16fd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   input  logic       last,
   input  cfg_type    cfg,
   output logic       has_result,
   output result_type result
);

   logic [15:0] pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] rcv_ff, rcv_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] seq_ff, seq_in;
   logic [15:0] len_ff, len_in;
   logic        hdr_ff, hdr_in;

   logic [15:0] crc_nx, rcv_nx, seq_nx, len_nx, pos_nx;
   logic [7:0]  cmd_nx;
   logic        hdr_nx;
   logic [16:0] p_wide;
   logic [16:0] frame_len;
   logic        in_payload;
   logic        ok;

   always_comb begin
      crc_nx = (pos_ff >= 16'd2) ? crc_byte(crc_ff, rcv_ff[7:0]) : crc_ff;
      rcv_nx = {rx_byte, rcv_ff[15:8]};
      cmd_nx = cmd_ff;
      seq_nx = seq_ff;
      len_nx = len_ff;
      hdr_nx = hdr_ff;
      case (pos_ff)
         PosSync0: if (rx_byte != SyncByte0) hdr_nx = 1'b1;
         PosSync1: if (rx_byte != SyncByte1) hdr_nx = 1'b1;
         PosVer:   if (rx_byte != cfg.protocol_version) hdr_nx = 1'b1;
         PosCmd:   cmd_nx = rx_byte;
         PosSeqLo: seq_nx = {seq_ff[15:8], rx_byte};
         PosSeqHi: seq_nx = {rx_byte, seq_ff[7:0]};
         PosLenLo: len_nx = {len_ff[15:8], rx_byte};
         PosLenHi: len_nx = {rx_byte, len_ff[7:0]};
         default: begin
         end
      endcase
      pos_nx = (pos_ff == PosMax) ? pos_ff : pos_ff + 16'd1;

      p_wide     = {1'b0, pos_ff};
      frame_len  = p_wide + 17'd1;
      in_payload = (p_wide >= PayloadOffs) && (p_wide < PayloadOffs + {1'b0, len_nx});
      ok = !hdr_nx
         && (frame_len >= FrameOvhd)
         && (len_nx <= {4'd0, cfg.max_payload})
         && (frame_len == {1'b0, len_nx} + FrameOvhd)
         && (crc_nx == rcv_nx);

      has_result = last || in_payload;
      result     = '0;
      if (last) begin
         result.item_kind       = KindSummary;
         result.frame_ok        = ok;
         result.command_code    = cmd_nx;
         result.sequence_number = seq_nx;
         result.payload_count   = len_nx;
      end else begin
         result.item_kind    = KindPayload;
         result.payload_byte = rx_byte;
      end

      pos_in = pos_ff;
      crc_in = crc_ff;
      rcv_in = rcv_ff;
      cmd_in = cmd_ff;
      seq_in = seq_ff;
      len_in = len_ff;
      hdr_in = hdr_ff;
      if (step) begin
         if (last) begin
            pos_in = '0;
            crc_in = CrcInit;
            rcv_in = '0;
            cmd_in = '0;
            seq_in = '0;
            len_in = '0;
            hdr_in = 1'b0;
         end else begin
            pos_in = pos_nx;
            crc_in = crc_nx;
            rcv_in = rcv_nx;
            cmd_in = cmd_nx;
            seq_in = seq_nx;
            len_in = len_nx;
            hdr_in = hdr_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         crc_ff <= CrcInit;
         rcv_ff <= '0;
         cmd_ff <= '0;
         seq_ff <= '0;
         len_ff <= '0;
         hdr_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         rcv_ff <= rcv_in;
         cmd_ff <= cmd_in;
         seq_ff <= seq_in;
         len_ff <= len_in;
         hdr_ff <= hdr_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step && last |=> pos_ff == 16'd0 && crc_ff == CrcInit && !hdr_ff)
      else $error("frame state not cleared after last byte");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      step && !last && pos_ff != PosMax |=> pos_ff == $past(pos_ff) + 16'd1)
      else $error("byte position did not advance");

   a_no_payload_before_len: assert property (@(posedge clock) disable iff (reset)
      has_result && result.item_kind == KindPayload |-> pos_ff >= 16'd8 && !last)
      else $error("payload item outside payload region");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for crc16_checked_frame_decoder_core: random and
// directed frame traffic, an in-bench frame decoder, field-by-field result
// checks. Depends on c16fd_pkg and the core RTL only.
module tb_top
   import c16fd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QuietLimit = 2000;
   localparam int LongBufferBytes = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = '0;
   logic        req_end_of_buffer = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_item_kind;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_frame_ok;
   logic [7:0]  rsp_command_code;
   logic [15:0] rsp_sequence_number;
   logic [15:0] rsp_payload_count;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   crc16_checked_frame_decoder_core u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .req_end_of_buffer   (req_end_of_buffer),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_item_kind       (rsp_item_kind),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_frame_ok        (rsp_frame_ok),
      .rsp_command_code    (rsp_command_code),
      .rsp_sequence_number (rsp_sequence_number),
      .rsp_payload_count   (rsp_payload_count),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // decoder copy: settings and frame state
   logic [7:0]  cfg_version = VersionReset;
   logic [11:0] cfg_max_payload = MaxPayloadReset;
   logic [15:0] frame_pos = '0;
   logic [15:0] crc_acc = CrcInit;
   logic [7:0]  held_cmd = '0;
   logic [15:0] held_seq = '0;
   logic [15:0] held_len = '0;
   logic [15:0] tail_pair = '0;
   logic        header_bad = 1'b0;

   result_type  decoded_items[$];
   logic [7:0]  frame_buf[$];

   int mismatches = 0;
   int bytes_sent = 0;
   int payload_checked = 0;
   int summaries_checked = 0;
   int frames_good = 0;
   int input_held_cycles = 0;
   int quiet_cycles = 0;

   bit steady_tx = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int stall_left = 0;
   int free_left = 0;
   int stall_pick;

   result_type want;
   result_type got;

   function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int k = 7; k >= 0; k--) begin
         fb = r[15] ^ data[k];
         r = {r[14:0], 1'b0};
         if (fb) begin
            r = r ^ CrcPoly;
         end
      end
      return r;
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic last);
      result_type  r;
      int unsigned p;
      p = frame_pos;
      if (p >= 2) begin
         crc_acc = crc16_next(crc_acc, tail_pair[7:0]);
      end
      tail_pair = {b, tail_pair[15:8]};
      case (frame_pos)
         PosSync0: if (b != SyncByte0) header_bad = 1'b1;
         PosSync1: if (b != SyncByte1) header_bad = 1'b1;
         PosVer:   if (b != cfg_version) header_bad = 1'b1;
         PosCmd:   held_cmd = b;
         PosSeqLo: held_seq[7:0] = b;
         PosSeqHi: held_seq[15:8] = b;
         PosLenLo: held_len[7:0] = b;
         PosLenHi: held_len[15:8] = b;
         default: ;
      endcase
      if (frame_pos != PosMax) begin
         frame_pos = frame_pos + 16'd1;
      end
      r = '0;
      if (!last) begin
         if (p >= 8 && p < 8 + held_len) begin
            r.item_kind = KindPayload;
            r.payload_byte = b;
            decoded_items.push_back(r);
         end
      end else begin
         r.item_kind = KindSummary;
         r.frame_ok = !header_bad && (p + 1 >= 10) && (held_len <= cfg_max_payload)
                      && (p + 1 == held_len + 10) && (crc_acc == tail_pair);
         r.command_code = held_cmd;
         r.sequence_number = held_seq;
         r.payload_count = held_len;
         decoded_items.push_back(r);
         frame_pos = '0;
         crc_acc = CrcInit;
         held_cmd = '0;
         held_seq = '0;
         held_len = '0;
         tail_pair = '0;
         header_bad = 1'b0;
      end
   endtask

   function automatic int tx_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (steady_tx || pick < 55) begin
         return 0;
      end
      if (pick < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // valid stays high after a request; settle() lowers it
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = tx_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_end_of_buffer <= last;
      do @(posedge clock); while (req_stall);
      decode_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_buf[i]) begin
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (decoded_items.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic build_frame(input logic [7:0] ver, input logic [7:0] cmd,
                              input logic [15:0] seq, input logic [15:0] len_field,
                              input int n_payload);
      logic [15:0] c;
      frame_buf = {SyncByte0, SyncByte1, ver, cmd, seq[7:0], seq[15:8],
                   len_field[7:0], len_field[15:8]};
      repeat (n_payload) frame_buf.push_back(8'($urandom));
      c = CrcInit;
      foreach (frame_buf[i]) begin
         c = crc16_next(c, frame_buf[i]);
      end
      frame_buf.push_back(c[7:0]);
      frame_buf.push_back(c[15:8]);
   endtask

   task automatic random_frame();
      int pick;
      int span;
      int len;
      int n;
      int cut;
      pick = $urandom_range(0, 99);
      span = (cfg_max_payload < 24) ? cfg_max_payload : 24;
      if ($urandom_range(0, 15) == 0) begin
         span = (cfg_max_payload < 300) ? cfg_max_payload : 300;
      end
      len = $urandom_range(0, span);
      build_frame(cfg_version, 8'($urandom), 16'($urandom), 16'(len), len);
      if (pick < 55) begin
         // well-formed frame as built
      end else if (pick < 64) begin
         cut = $urandom_range(0, frame_buf.size() - 1);
         frame_buf[cut] = frame_buf[cut] ^ 8'($urandom_range(1, 255));
      end else if (pick < 69) begin
         build_frame(cfg_version ^ 8'($urandom_range(1, 255)), 8'($urandom),
                     16'($urandom), 16'(len), len);
      end else if (pick < 74) begin
         if (cfg_max_payload < 60) begin
            len = cfg_max_payload + 1 + $urandom_range(0, 2);
            build_frame(cfg_version, 8'($urandom), 16'($urandom), 16'(len), len);
         end else begin
            build_frame(cfg_version, 8'($urandom), 16'($urandom),
                        16'hF000 | 16'($urandom), $urandom_range(0, 20));
         end
      end else if (pick < 81) begin
         if (len > 0 && $urandom_range(0, 1) == 1) begin
            n = len - $urandom_range(1, (len < 3) ? len : 3);
         end else begin
            n = len + $urandom_range(1, 3);
         end
         build_frame(cfg_version, 8'($urandom), 16'($urandom), 16'(len), n);
      end else if (pick < 86) begin
         cut = $urandom_range(1, frame_buf.size() - 1);
         frame_buf = frame_buf[0:cut-1];
      end else if (pick < 90) begin
         repeat ($urandom_range(1, 3)) frame_buf.push_back(8'($urandom));
      end else begin
         frame_buf = {};
         repeat ($urandom_range(1, 20)) frame_buf.push_back(8'($urandom));
         if ($urandom_range(0, 1) == 1) begin
            frame_buf[0] = SyncByte0;
         end
      end
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         RegVersion:    cfg_version = value[7:0];
         RegMaxPayload: cfg_max_payload = value[11:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_read(input reg_index_type idx, output logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_settings(input logic [7:0] ver, input logic [11:0] max_len);
      logic [31:0] rd;
      settle();
      csr_write(RegVersion, {24'($urandom), ver});
      csr_write(RegMaxPayload, {20'($urandom), max_len});
      csr_read(RegVersion, rd);
      if (rd !== {24'd0, cfg_version}) begin
         mismatches++;
         $error("protocol_version: expected %0h, got %0h", cfg_version, rd);
      end
      csr_read(RegMaxPayload, rd);
      if (rd !== {20'd0, cfg_max_payload}) begin
         mismatches++;
         $error("max_payload: expected %0h, got %0h", cfg_max_payload, rd);
      end
   endtask

   task automatic run_random_traffic(input int budget);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         steady_tx = ($urandom_range(0, 4) == 0);
         random_frame();
         send_frame();
      end
      steady_tx = 1'b0;
   endtask

   task automatic test_directed_frames();
      build_frame(cfg_version, 8'hFF, 16'hFFFF, 16'd0, 0);
      send_frame();
      build_frame(cfg_version, 8'h00, 16'h0000, 16'd1, 1);
      send_frame();
      frame_buf = {8'hFF};
      send_frame();
      build_frame(cfg_version, 8'h80, 16'h8001, 16'd0, 0);
      frame_buf = frame_buf[0:4];
      send_frame();
   endtask

   task automatic test_default_traffic();
      run_random_traffic(400);
   endtask

   // receiver holds off while a long payload keeps arriving
   task automatic test_output_backpressure();
      settle();
      steady_tx = 1'b1;
      hold_request = 1'b1;
      build_frame(cfg_version, 8'($urandom), 16'($urandom), 16'd48, 48);
      send_frame();
      steady_tx = 1'b0;
   endtask

   task automatic test_settings_sweep();
      apply_settings(8'd0, 12'd0);
      run_random_traffic(200);
      apply_settings(8'd255, 12'd4095);
      build_frame(cfg_version, 8'($urandom), 16'($urandom), 16'd200, 200);
      send_frame();
      run_random_traffic(250);
      apply_settings(8'($urandom), 12'($urandom_range(0, 200)));
      run_random_traffic(300);
      apply_settings(VersionReset, MaxPayloadReset);
      run_random_traffic(200);
   endtask

   // length field far beyond the buffer; every byte past the header but the last is passed on
   task automatic test_long_buffer();
      settle();
      steady_tx = 1'b1;
      build_frame(cfg_version, 8'h5A, 16'h1234, 16'hFFFF, 0);
      while (frame_buf.size() < LongBufferBytes) frame_buf.push_back(8'($urandom));
      send_frame();
      steady_tx = 1'b0;
   endtask

   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 120;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (free_left > 0) begin
         free_left--;
         rsp_stall <= 1'b0;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 60) begin
            rsp_stall <= 1'b0;
         end else if (stall_pick < 88) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else if (stall_pick < 93) begin
            stall_left = $urandom_range(8, 30);
            rsp_stall <= 1'b1;
         end else begin
            free_left = $urandom_range(20, 80);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got.item_kind = rsp_item_kind;
         got.payload_byte = rsp_payload_byte;
         got.frame_ok = rsp_frame_ok;
         got.command_code = rsp_command_code;
         got.sequence_number = rsp_sequence_number;
         got.payload_count = rsp_payload_count;
         if (decoded_items.size() == 0) begin
            mismatches++;
            $error("unexpected result: kind %0d byte %0h", got.item_kind, got.payload_byte);
         end else begin
            want = decoded_items.pop_front();
            if (want.item_kind == KindSummary) begin
               summaries_checked++;
               if (want.frame_ok) frames_good++;
            end else begin
               payload_checked++;
            end
            if (got.item_kind !== want.item_kind) begin
               mismatches++;
               $error("item_kind: expected %0d, got %0d", want.item_kind, got.item_kind);
            end
            if (got.payload_byte !== want.payload_byte) begin
               mismatches++;
               $error("payload_byte: expected %0h, got %0h", want.payload_byte,
                      got.payload_byte);
            end
            if (got.frame_ok !== want.frame_ok) begin
               mismatches++;
               $error("frame_ok: expected %0d, got %0d", want.frame_ok, got.frame_ok);
            end
            if (got.command_code !== want.command_code) begin
               mismatches++;
               $error("command_code: expected %0h, got %0h", want.command_code,
                      got.command_code);
            end
            if (got.sequence_number !== want.sequence_number) begin
               mismatches++;
               $error("sequence_number: expected %0h, got %0h", want.sequence_number,
                      got.sequence_number);
            end
            if (got.payload_count !== want.payload_count) begin
               mismatches++;
               $error("payload_count: expected %0h, got %0h", want.payload_count,
                      got.payload_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (req_valid && req_stall) input_held_cycles++;
      if (quiet_cycles >= QuietLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_default_traffic();
      test_output_backpressure();
      test_settings_sweep();
      test_long_buffer();
      settle();
      if (decoded_items.size() != 0) begin
         mismatches++;
         $error("%0d results never arrived", decoded_items.size());
      end
      $display("Sent %0d bytes; checked %0d payload bytes and %0d summaries (%0d frames good).",
               bytes_sent, payload_checked, summaries_checked, frames_good);
      $display("Input held off %0d cycles; versions 0/1/255, max payload 0/128/4095, %0s",
               input_held_cycles, "oversized length field included.");
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/c16fd_pkg.sv
design/c16fd_csr.sv
design/c16fd_frame.sv
design/crc16_checked_frame_decoder_core.sv
verif/tb_top.sv
